@@ src/sba_pkg.sv @@
// Shared types and constants of the size-class buffer allocator.
`default_nettype none

package sba_pkg;

    // Widest slot index over the allowed slot counts (up to 4096 slots).
    localparam int SLOT_W      = 12;
    localparam int REQ_W       = 16;
    localparam int OUT_ADDR_W  = 48;
    localparam int CFG_W       = 48;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] CLS_SMALL = 2'd0;
    localparam logic [1:0] CLS_MID   = 2'd1;
    localparam logic [1:0] CLS_BIG   = 2'd2;
    localparam logic [1:0] CLS_NONE  = 2'd3;

    localparam logic [1:0] REG_BASE        = 2'd0;
    localparam logic [1:0] REG_SMALL_COUNT = 2'd1;
    localparam logic [1:0] REG_MID_COUNT   = 2'd2;
    localparam logic [1:0] REG_BIG_COUNT   = 2'd3;

    // Command kinds passed from front to back
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    localparam int SHIFT_SMALL = 7;
    localparam int SHIFT_MID   = 8;
    localparam int SHIFT_BIG   = 12;

    localparam int BYTES_SMALL = 128;
    localparam int BYTES_MID   = 256;
    localparam int BYTES_BIG   = 4096;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        fit;   // request fits small, mid, big (bit 0 small)
        logic [1:0]        cls;
        logic [SLOT_W-1:0] slot;
    } sba_cmd_t;

    typedef struct packed {
        logic              init;
        logic              clr;
        logic              rd_ring;
        logic              rd_taken;
        logic              pop;
        logic              push;
        logic [SLOT_W-1:0] slot;
    } sba_ctl_t;

    typedef struct packed {
        logic              nonempty;
        logic              notfull;
        logic [SLOT_W-1:0] head_slot;
        logic              taken;
    } sba_sts_t;

endpackage

`default_nettype wire

@@ src/size_class_buffer_allocator.sv @@
// Top level of the size-class buffer allocator: registers, region map, front and back.
`default_nettype none

// Hands out fixed buffers of 128, 256 and 4096 bytes from three regions laid
// end to end from base_addr (small, then mid, then big). Each request item
// (s_axis) is either an allocate (tuser = 0) of req_bytes, answered with the
// smallest class that fits and still has a free slot, or a free (tuser = 1)
// of free_addr, checked for range, alignment and ownership. Every request
// gives exactly one result item on m_axis: ok, the buffer address (0 on
// failure and on every free) and the class (3 on failure). A front stage
// registers and classifies items and hands them through a two-entry queue
// to the back, which owns the free rings and taken bits, so inputs keep
// flowing while a result waits. The front registers each item; in the
// back a successful allocate, or a free that is aligned and in range, does
// a registered read of the ring or taken memory, then the update, and no
// new item is taken in between; other requests are answered directly from
// the idle state. After reset, and after any write to a count register, a
// clearing pass over slot indexes 0 to max(SMALL_SLOTS, MID_SLOTS,
// BIG_SLOTS) - 1 (255 by default) reloads the rings with ascending slot numbers and clears
// the taken bits; no item is taken during it and every buffer held outside
// is forgotten. Counts above a class's slot count are saturated. A base
// write keeps all buffers. Write configuration only while no request is in
// flight.
module size_class_buffer_allocator #(
    parameter int SMALL_SLOTS = 256,
    parameter int MID_SLOTS   = 64,
    parameter int BIG_SLOTS   = 64,
    parameter int ADDR_BITS   = 48
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Request items
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [sba_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [15:0] req_bytes, [63:16] free_addr
    input  wire logic                              s_axis_tuser,  // [0] func
    // Result items
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [sba_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // [0] ok, [48:1] buf_addr,
                                                                  // [50:49] size_class, rest zero
    // Configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [sba_pkg::CFG_W-1:0]         cfg_data
);
    import sba_pkg::*;

    localparam int XW  = (ADDR_BITS > 48) ? ADDR_BITS : 48;
    localparam int SCW = $clog2(SMALL_SLOTS + 1);
    localparam int MCW = $clog2(MID_SLOTS + 1);
    localparam int BCW = $clog2(BIG_SLOTS + 1);

    logic [CFG_W-1:0] base_addr_reg;
    logic [8:0]       small_count_reg;
    logic [6:0]       mid_count_reg;
    logic [6:0]       big_count_reg;

    logic [SCW-1:0]   small_eff;
    logic [MCW-1:0]   mid_eff;
    logic [BCW-1:0]   big_eff;
    logic [XW-1:0]    start_mid;
    logic [XW-1:0]    start_big;
    logic [XW-1:0]    span_end;
    logic [XW-1:0]    base_ext;
    logic [XW-1:0]    small_base_reg;
    logic [XW-1:0]    mid_base_reg;
    logic [XW-1:0]    big_base_reg;

    logic             restart;
    logic             busy;
    sba_cmd_t         f_cmd;
    logic             f_valid;
    logic             f_ready;
    sba_cmd_t         b_cmd;
    logic             b_valid;
    logic             b_ready;

    // Configuration registers; any count write restarts all three classes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg   <= '0;
            small_count_reg <= 9'd256;
            mid_count_reg   <= 7'd64;
            big_count_reg   <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE:        base_addr_reg   <= cfg_data;
                REG_SMALL_COUNT: small_count_reg <= cfg_data[8:0];
                REG_MID_COUNT:   mid_count_reg   <= cfg_data[6:0];
                REG_BIG_COUNT:   big_count_reg   <= cfg_data[6:0];
            endcase
        end
    end

    assign restart = cfg_we && (cfg_index != REG_BASE);

    // Saturate each count at its class's slot count
    assign small_eff = (32'(small_count_reg) > SMALL_SLOTS) ? SCW'(SMALL_SLOTS)
                                                           : SCW'(small_count_reg);
    assign mid_eff   = (32'(mid_count_reg) > MID_SLOTS) ? MCW'(MID_SLOTS)
                                                       : MCW'(mid_count_reg);
    assign big_eff   = (32'(big_count_reg) > BIG_SLOTS) ? BCW'(BIG_SLOTS)
                                                       : BCW'(big_count_reg);

    // Region bounds as byte offsets from base
    assign start_mid = XW'(small_eff) << SHIFT_SMALL;
    assign start_big = start_mid + (XW'(mid_eff) << SHIFT_MID);
    assign span_end  = start_big + (XW'(big_eff) << SHIFT_BIG);
    assign base_ext  = XW'(base_addr_reg);

    // Hold the absolute start of each region; refreshed every cycle
    always_ff @(posedge clk)
    begin
        small_base_reg <= base_ext;
        mid_base_reg   <= base_ext + start_mid;
        big_base_reg   <= base_ext + start_big;
    end

    sba_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .busy          (busy),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .base_addr     (base_addr_reg),
        .start_mid     (start_mid),
        .start_big     (start_big),
        .span_end      (span_end),
        .q_data        (f_cmd),
        .q_valid       (f_valid),
        .q_ready       (f_ready)
    );

    sba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_cmd),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (b_cmd),
        .rd_valid (b_valid),
        .rd_ready (b_ready)
    );

    sba_back #(
        .SMALL_SLOTS (SMALL_SLOTS),
        .MID_SLOTS   (MID_SLOTS),
        .BIG_SLOTS   (BIG_SLOTS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart),
        .busy          (busy),
        .q_data        (b_cmd),
        .q_valid       (b_valid),
        .q_ready       (b_ready),
        .small_eff     (small_eff),
        .mid_eff       (mid_eff),
        .big_eff       (big_eff),
        .small_base    (small_base_reg),
        .mid_base      (mid_base_reg),
        .big_base      (big_base_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ src/sba_class.sv @@
// One size class: free ring memory, taken-bit memory and ring pointers.
`default_nettype none

module sba_class #(
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [$clog2(DEPTH+1)-1:0] count_eff,
    input  wire sba_pkg::sba_ctl_t          ctl,
    output sba_pkg::sba_sts_t               sts
);
    import sba_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [IW-1:0] ring_mem  [DEPTH];
    logic          taken_mem [DEPTH];

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [IW-1:0] ring_q_reg;
    logic          taken_q_reg;

    logic [CW:0]   tail_sum;
    logic [CW:0]   tail_wrap;
    logic [IW-1:0] tail;
    logic [IW-1:0] addr;
    logic          in_range;
    logic          ring_we;
    logic [IW-1:0] ring_waddr;
    logic          taken_we;

    assign addr      = ctl.slot[IW-1:0];
    assign in_range  = {1'b0, ctl.slot} < (SLOT_W+1)'(DEPTH);
    assign tail_sum  = (CW+1)'(head_reg) + (CW+1)'(fill_reg);
    assign tail_wrap = tail_sum - (CW+1)'(DEPTH);
    assign tail      = (tail_sum >= (CW+1)'(DEPTH)) ? tail_wrap[IW-1:0] : tail_sum[IW-1:0];

    assign ring_we    = (ctl.clr && in_range) || ctl.push;
    assign ring_waddr = ctl.clr ? addr : tail;
    assign taken_we   = (ctl.clr && in_range) || ctl.push || ctl.pop;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= addr;
        end
        if (taken_we)
        begin
            taken_mem[addr] <= ctl.pop;
        end
        if (ctl.rd_ring)
        begin
            ring_q_reg <= ring_mem[head_reg];
        end
        if (ctl.rd_taken)
        begin
            taken_q_reg <= taken_mem[addr];
        end
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctl.init)
        begin
            head_next = '0;
            fill_next = count_eff;
        end
        else if (ctl.pop)
        begin
            head_next = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
        else if (ctl.push)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    assign sts.nonempty  = (fill_reg != '0);
    assign sts.notfull   = (fill_reg < CW'(DEPTH));
    assign sts.head_slot = SLOT_W'(ring_q_reg);
    assign sts.taken     = taken_q_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("ring fill above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.pop && !ctl.init) |-> (fill_reg != '0))
        else $error("pop from empty ring");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !ctl.pop && (fill_reg < CW'(DEPTH)))
        else $error("push into full ring or together with pop");

endmodule

`default_nettype wire

@@ src/sba_queue.sv @@
// Two-entry command queue between the front and back of the allocator.
`default_nettype none

module sba_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sba_pkg::sba_cmd_t wr_data,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    output sba_pkg::sba_cmd_t      rd_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready
);
    import sba_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    sba_cmd_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   cnt_reg;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = (cnt_reg != NW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/sba_front.sv @@
// Front end: accepts request items and classifies them into commands.
`default_nettype none

module sba_front #(
    parameter  int ADDR_BITS = 48,
    localparam int XW        = (ADDR_BITS > 48) ? ADDR_BITS : 48
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             busy,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [sba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tuser,
    input  wire logic [sba_pkg::CFG_W-1:0]        base_addr,
    input  wire logic [XW-1:0]                    start_mid,
    input  wire logic [XW-1:0]                    start_big,
    input  wire logic [XW-1:0]                    span_end,
    output sba_pkg::sba_cmd_t                     q_data,
    output logic                                  q_valid,
    input  wire logic                             q_ready
);
    import sba_pkg::*;

    localparam logic [XW-1:0] AB_MASK = {XW{1'b1}} >> (XW - ADDR_BITS);

    logic             f_valid_reg;
    logic             f_func_reg;
    logic [2:0]       f_fit_reg;
    logic [XW-1:0]    f_off_reg;

    logic             accept;
    logic [REQ_W-1:0] req;
    logic [XW-1:0]    diff;
    logic [2:0]       fit;
    logic [1:0]       cls;
    logic [XW-1:0]    rel;
    logic             aligned;
    logic [SLOT_W-1:0] slot;

    assign s_axis_tready = !busy && (!f_valid_reg || q_ready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req           = s_axis_tdata[REQ_W-1:0];
    assign diff          = XW'(s_axis_tdata[IN_TDATA_W-1:REQ_W]) - XW'(base_addr);

    assign fit[0] = (req <= REQ_W'(BYTES_SMALL));
    assign fit[1] = (req <= REQ_W'(BYTES_MID));
    assign fit[2] = (req <= REQ_W'(BYTES_BIG));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_func_reg <= s_axis_tuser;
            f_fit_reg  <= fit;
            f_off_reg  <= diff & AB_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (q_ready)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    // Region decode: regions are back to back, so the first bound above the
    // offset names the class.
    always_comb
    begin
        if (f_off_reg < start_mid)
        begin
            cls = CLS_SMALL;
            rel = f_off_reg;
        end
        else if (f_off_reg < start_big)
        begin
            cls = CLS_MID;
            rel = f_off_reg - start_mid;
        end
        else if (f_off_reg < span_end)
        begin
            cls = CLS_BIG;
            rel = f_off_reg - start_big;
        end
        else
        begin
            cls = CLS_NONE;
            rel = '0;
        end
    end

    always_comb
    begin
        unique case (cls)
            CLS_SMALL:
            begin
                aligned = (rel[SHIFT_SMALL-1:0] == '0);
                slot    = rel[SHIFT_SMALL +: SLOT_W];
            end
            CLS_MID:
            begin
                aligned = (rel[SHIFT_MID-1:0] == '0);
                slot    = rel[SHIFT_MID +: SLOT_W];
            end
            CLS_BIG:
            begin
                aligned = (rel[SHIFT_BIG-1:0] == '0);
                slot    = rel[SHIFT_BIG +: SLOT_W];
            end
            default:
            begin
                aligned = 1'b0;
                slot    = '0;
            end
        endcase
    end

    always_comb
    begin
        q_data.fit  = f_fit_reg;
        q_data.cls  = cls;
        q_data.slot = slot;
        if (f_func_reg == FUNC_ALLOC)
        begin
            q_data.kind = KIND_ALLOC;
        end
        else if (aligned)
        begin
            q_data.kind = KIND_FREE;
        end
        else
        begin
            q_data.kind = KIND_BAD;
        end
    end

    assign q_valid = f_valid_reg;

endmodule

`default_nettype wire

@@ src/sba_back.sv @@
// Back end: clearing pass, ring pops and pushes, result register.
`default_nettype none

module sba_back #(
    parameter  int SMALL_SLOTS = 256,
    parameter  int MID_SLOTS   = 64,
    parameter  int BIG_SLOTS   = 64,
    parameter  int ADDR_BITS   = 48,
    localparam int XW          = (ADDR_BITS > 48) ? ADDR_BITS : 48,
    localparam int SCW         = $clog2(SMALL_SLOTS + 1),
    localparam int MCW         = $clog2(MID_SLOTS + 1),
    localparam int BCW         = $clog2(BIG_SLOTS + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              restart,
    output logic                                   busy,
    input  wire sba_pkg::sba_cmd_t                 q_data,
    input  wire logic                              q_valid,
    output logic                                   q_ready,
    input  wire logic [SCW-1:0]                    small_eff,
    input  wire logic [MCW-1:0]                    mid_eff,
    input  wire logic [BCW-1:0]                    big_eff,
    input  wire logic [XW-1:0]                     small_base,
    input  wire logic [XW-1:0]                     mid_base,
    input  wire logic [XW-1:0]                     big_base,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [sba_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import sba_pkg::*;

    localparam int MAX_SM = (SMALL_SLOTS > MID_SLOTS) ? SMALL_SLOTS : MID_SLOTS;
    localparam int MAX_D  = (MAX_SM > BIG_SLOTS) ? MAX_SM : BIG_SLOTS;
    localparam int CLRW   = (MAX_D > 1) ? $clog2(MAX_D) : 1;
    localparam logic [XW-1:0] AB_MASK = {XW{1'b1}} >> (XW - ADDR_BITS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [CLRW-1:0] clr_idx_reg, clr_idx_next;
    sba_cmd_t        cur_reg, cur_next;
    logic [1:0]      cls_reg, cls_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_ok_reg;
    logic [OUT_ADDR_W-1:0] out_addr_reg;
    logic [1:0]            out_cls_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  load_ok;
    logic [OUT_ADDR_W-1:0] load_addr;
    logic [1:0]            load_cls;

    sba_ctl_t [2:0] ctl;
    sba_sts_t [2:0] sts;

    logic [2:0]      hit;
    logic [1:0]      pick;
    logic [XW-1:0]   slot_x;
    logic [XW-1:0]   addr_sum;
    logic [XW-1:0]   addr_masked;

    sba_class #(.DEPTH(SMALL_SLOTS)) u_small (
        .clk       (clk),
        .rst_n     (rst_n),
        .count_eff (small_eff),
        .ctl       (ctl[0]),
        .sts       (sts[0])
    );

    sba_class #(.DEPTH(MID_SLOTS)) u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .count_eff (mid_eff),
        .ctl       (ctl[1]),
        .sts       (sts[1])
    );

    sba_class #(.DEPTH(BIG_SLOTS)) u_big (
        .clk       (clk),
        .rst_n     (rst_n),
        .count_eff (big_eff),
        .ctl       (ctl[2]),
        .sts       (sts[2])
    );

    // Smallest fitting class that still has a free slot
    assign hit[0] = q_data.fit[0] && sts[0].nonempty;
    assign hit[1] = q_data.fit[1] && sts[1].nonempty;
    assign hit[2] = q_data.fit[2] && sts[2].nonempty;
    assign pick   = hit[0] ? CLS_SMALL : (hit[1] ? CLS_MID : CLS_BIG);

    assign slot_x = XW'(sts[cls_reg].head_slot);

    always_comb
    begin
        unique case (cls_reg)
            CLS_SMALL: addr_sum = small_base + (slot_x << SHIFT_SMALL);
            CLS_MID:   addr_sum = mid_base + (slot_x << SHIFT_MID);
            CLS_BIG:   addr_sum = big_base + (slot_x << SHIFT_BIG);
            default:   addr_sum = '0;
        endcase
    end

    assign addr_masked = addr_sum & AB_MASK;
    assign out_free    = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        cur_next       = cur_reg;
        cls_next       = cls_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_load       = 1'b0;
        load_ok        = 1'b0;
        load_addr      = '0;
        load_cls       = CLS_NONE;
        q_ready        = 1'b0;
        ctl            = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctl[i].clr  = 1'b1;
                    ctl[i].slot = SLOT_W'(clr_idx_reg);
                end
                if (clr_idx_reg == CLRW'(MAX_D - 1))
                begin
                    // last sweep cycle: load pointers from the current counts
                    for (int i = 0; i < 3; i++)
                    begin
                        ctl[i].init = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_ready  = 1'b1;
                    cur_next = q_data;
                    case (q_data.kind)
                        KIND_ALLOC:
                        begin
                            if (hit != 3'b000)
                            begin
                                cls_next            = pick;
                                ctl[pick].rd_ring   = 1'b1;
                                state_next          = ST_EXEC;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        KIND_FREE:
                        begin
                            cls_next                   = q_data.cls;
                            ctl[q_data.cls].rd_taken   = 1'b1;
                            ctl[q_data.cls].slot       = q_data.slot;
                            state_next                 = ST_EXEC;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                out_load   = 1'b1;
                if (cur_reg.kind == KIND_ALLOC)
                begin
                    ctl[cls_reg].pop  = 1'b1;
                    ctl[cls_reg].slot = sts[cls_reg].head_slot;
                    load_ok           = 1'b1;
                    load_addr         = addr_masked[OUT_ADDR_W-1:0];
                    load_cls          = cls_reg;
                end
                else if (sts[cls_reg].taken && sts[cls_reg].notfull)
                begin
                    ctl[cls_reg].push = 1'b1;
                    ctl[cls_reg].slot = cur_reg.slot;
                    load_ok           = 1'b1;
                    load_cls          = cls_reg;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (restart)
        begin
            state_next   = ST_CLEAR;
            clr_idx_next = '0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        cls_reg <= cls_next;
        if (out_load)
        begin
            out_ok_reg   <= load_ok;
            out_addr_reg <= load_addr;
            out_cls_reg  <= load_cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign busy          = (state_reg == ST_CLEAR);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_ADDR_W - 3){1'b0}},
                            out_cls_reg, out_addr_reg, out_ok_reg};

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_ready)
        else $error("command taken during clearing pass");

    a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !out_valid_reg)
        else $error("result register busy when a command completes");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (state_reg == ST_CLEAR) && (clr_idx_reg == '0))
        else $error("count write did not start a clearing pass");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the size-class buffer allocator: directed and random requests against a local model.
module tb;
    import sba_pkg::*;

    localparam int              MAX_GAP     = 18;
    localparam int              HOLD_CYCLES = 400;
    localparam int              CLEAR_WAIT  = 300;
    localparam int              DRAIN_WAIT  = 16;
    localparam int              CYCLE_LIMIT = 600000;
    localparam int              PRINT_LIMIT = 40;
    localparam longint unsigned ADDR_MASK   = 64'h0000_FFFF_FFFF_FFFF;

    // How the address of a free is chosen when the item is about to be offered
    typedef enum logic [1:0] {ADDR_AS_IS, ADDR_HELD, ADDR_HELD_SKEW, ADDR_IN_REGION} addr_pick_t;

    typedef struct {
        logic                  func;
        logic [REQ_W-1:0]      req_bytes;
        logic [OUT_ADDR_W-1:0] free_addr;
        addr_pick_t            pick;
        int                    gap;
    } request_t;

    typedef struct {
        logic                  ok;
        logic [OUT_ADDR_W-1:0] buf_addr;
        logic [1:0]            size_class;
    } reply_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = FUNC_ALLOC;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we        = 1'b0;
    logic [1:0]             cfg_index     = REG_BASE;
    logic [CFG_W-1:0]       cfg_data      = '0;

    // Local copy of the allocator state
    logic [SLOT_W-1:0]      free_ring [3][256];
    bit                     taken_bit [3][256];
    int                     ring_head [3];
    int                     ring_fill [3];
    int                     eff_count [3];
    logic [OUT_ADDR_W-1:0]  base_reg;
    int                     small_reg;
    int                     mid_reg;
    int                     big_reg;
    longint unsigned        held_off [$];   // offsets from base of buffers handed out

    request_t               request_q [$];
    reply_t                 reply_q [$];
    request_t               drv_item;
    bit                     drv_busy    = 1'b0;
    int                     tx_gap_max  = MAX_GAP;
    int                     rx_gap_max  = MAX_GAP;
    int                     rx_wait     = 0;
    int                     hold_req    = 0;
    int                     hold_seen   = 0;
    int                     hold_left   = 0;
    int                     cycle_count = 0;
    int                     fail_count  = 0;

    size_class_buffer_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int depth_of(int c);
        return (c == 0) ? 256 : 64;
    endfunction

    function automatic int shift_of(int c);
        return (c == 0) ? SHIFT_SMALL : (c == 1) ? SHIFT_MID : SHIFT_BIG;
    endfunction

    // Byte offset of the start of region c from base
    function automatic longint unsigned region_base(int c);
        longint unsigned off;
        off = 0;
        for (int i = 0; i < c; i++)
            off += 64'(eff_count[i]) << shift_of(i);
        return off;
    endfunction

    // Reload all rings with ascending slots, saturate counts, forget held buffers
    function automatic void reload_pools();
        int raw;
        for (int c = 0; c < 3; c++)
        begin
            raw = (c == 0) ? small_reg : (c == 1) ? mid_reg : big_reg;
            eff_count[c] = (raw > depth_of(c)) ? depth_of(c) : raw;
            ring_head[c] = 0;
            ring_fill[c] = eff_count[c];
            for (int i = 0; i < 256; i++)
            begin
                free_ring[c][i] = SLOT_W'(i);
                taken_bit[c][i] = 1'b0;
            end
        end
        held_off.delete();
    endfunction

    // Apply one allocate or free to the local state and return its result item
    function automatic reply_t serve_request(request_t rq);
        reply_t          rp;
        longint unsigned off;
        longint unsigned start;
        longint unsigned len;
        longint unsigned rel;
        int              slot;
        int              d;
        int              sh;
        bit              done;
        rp.ok         = 1'b0;
        rp.buf_addr   = '0;
        rp.size_class = CLS_NONE;
        done          = 1'b0;
        if (rq.func == FUNC_ALLOC)
        begin
            // smallest class that fits and still has a free slot
            for (int c = 0; c < 3; c++)
            begin
                d  = depth_of(c);
                sh = shift_of(c);
                if (!done && rq.req_bytes <= (1 << sh) && ring_fill[c] > 0)
                begin
                    slot = free_ring[c][ring_head[c]] % d;
                    off  = region_base(c) + (64'(slot) << sh);
                    ring_head[c] = (ring_head[c] + 1) % d;
                    ring_fill[c]--;
                    taken_bit[c][slot] = 1'b1;
                    held_off.insert(held_off.size(), off);
                    rp.ok         = 1'b1;
                    rp.buf_addr   = OUT_ADDR_W'((64'(base_reg) + off) & ADDR_MASK);
                    rp.size_class = 2'(c);
                    done          = 1'b1;
                end
            end
        end
        else
        begin
            off = (64'(rq.free_addr) - 64'(base_reg)) & ADDR_MASK;
            // first region the offset lands in decides, even when regions wrap
            for (int c = 0; c < 3; c++)
            begin
                d     = depth_of(c);
                sh    = shift_of(c);
                start = region_base(c);
                len   = 64'(eff_count[c]) << sh;
                if (!done && off >= start && off - start < len)
                begin
                    done = 1'b1;
                    rel  = off - start;
                    slot = int'(rel >> sh);
                    if ((rel & ((64'd1 << sh) - 1)) == 0 && slot < d && taken_bit[c][slot]
                        && ring_fill[c] < d)
                    begin
                        free_ring[c][(ring_head[c] + ring_fill[c]) % d] = SLOT_W'(slot);
                        ring_fill[c]++;
                        taken_bit[c][slot] = 1'b0;
                        rp.ok         = 1'b1;
                        rp.size_class = 2'(c);
                        for (int i = 0; i < held_off.size(); i++)
                        begin
                            if (held_off[i] == off)
                            begin
                                held_off.delete(i);
                                break;
                            end
                        end
                    end
                end
            end
        end
        return rp;
    endfunction

    function automatic logic [OUT_ADDR_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[OUT_ADDR_W-1:0];
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (fail_count < PRINT_LIMIT)
            $display("MISMATCH %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    task automatic push_request(logic func, logic [REQ_W-1:0] req, logic [OUT_ADDR_W-1:0] addr,
                                addr_pick_t pick);
        request_t rq;
        rq.func      = func;
        rq.req_bytes = req;
        rq.free_addr = addr;
        rq.pick      = pick;
        rq.gap       = $urandom_range(0, tx_gap_max);
        request_q.insert(request_q.size(), rq);
    endtask

    // Mostly well-formed traffic: fitting sizes and frees of buffers really held
    task automatic run_random(int n, int alloc_pct);
        logic [REQ_W-1:0] req;
        addr_pick_t       pick;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: req = REQ_W'($urandom_range(0, BYTES_SMALL));
                    4, 5:       req = REQ_W'($urandom_range(BYTES_SMALL + 1, BYTES_MID));
                    6, 7:       req = REQ_W'($urandom_range(BYTES_MID + 1, BYTES_BIG));
                    8:          req = REQ_W'($urandom_range(BYTES_BIG + 1, 65535));
                    default:    req = REQ_W'($urandom);
                endcase
                push_request(FUNC_ALLOC, req, rand48(), ADDR_AS_IS);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: pick = ADDR_HELD;
                    6:                pick = ADDR_HELD_SKEW;
                    7, 8:             pick = ADDR_IN_REGION;
                    default:          pick = ADDR_AS_IS;
                endcase
                push_request(FUNC_FREE, REQ_W'($urandom), rand48(), pick);
            end
        end
    endtask

    // Wait until every item went through and every result came back, then drain
    task automatic wait_idle();
        while (request_q.size() != 0 || drv_busy || s_axis_tvalid || reply_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [OUT_ADDR_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_BASE:        base_reg  = val;
            REG_SMALL_COUNT: small_reg = int'(val[8:0]);
            REG_MID_COUNT:   mid_reg   = int'(val[6:0]);
            default:         big_reg   = int'(val[6:0]);
        endcase
        // a count write restarts the clearing pass: let it finish before the next write
        if (idx != REG_BASE)
        begin
            reload_pools();
            repeat (CLEAR_WAIT) @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Request driver: hold an item until accepted, then advance after its gap
    always @(posedge clk)
    begin : request_driver
        logic            offer;
        longint unsigned pick_off;
        int              pick_cls;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                reply_q.insert(reply_q.size(), serve_request(drv_item));
                drv_busy = 1'b0;
            end
            offer = s_axis_tvalid && !s_axis_tready;
            if (!offer)
            begin
                if (!drv_busy && request_q.size() > 0)
                begin
                    drv_item = request_q[0];
                    request_q.delete(0);
                    drv_busy = 1'b1;
                end
                if (drv_busy)
                begin
                    if (drv_item.gap > 0)
                        drv_item.gap--;
                    else
                    begin
                        // every earlier item is accepted now, so the held list is exact
                        if ((drv_item.pick == ADDR_HELD || drv_item.pick == ADDR_HELD_SKEW)
                            && held_off.size() > 0)
                        begin
                            pick_off = held_off[$urandom_range(0, held_off.size() - 1)];
                            if (drv_item.pick == ADDR_HELD_SKEW)
                                pick_off += $urandom_range(1, BYTES_SMALL - 1);
                            drv_item.free_addr =
                                OUT_ADDR_W'((64'(base_reg) + pick_off) & ADDR_MASK);
                        end
                        else if (drv_item.pick == ADDR_IN_REGION
                                 && eff_count[0] + eff_count[1] + eff_count[2] > 0)
                        begin
                            pick_cls = $urandom_range(0, 2);
                            while (eff_count[pick_cls] == 0)
                                pick_cls = (pick_cls + 1) % 3;
                            pick_off = region_base(pick_cls)
                                + (64'($urandom_range(0, eff_count[pick_cls] - 1))
                                   << shift_of(pick_cls));
                            drv_item.free_addr =
                                OUT_ADDR_W'((64'(base_reg) + pick_off) & ADDR_MASK);
                        end
                        offer = 1'b1;
                        s_axis_tdata <= {drv_item.free_addr, drv_item.req_bytes};
                        s_axis_tuser <= drv_item.func;
                    end
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // Result monitor: check each accepted item, then draw the next stall
    always @(posedge clk)
    begin : reply_monitor
        reply_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (reply_q.size() == 0)
                    report_mismatch("result with no request outstanding",
                                    64'(m_axis_tdata), 64'd0);
                else
                begin
                    want = reply_q[0];
                    reply_q.delete(0);
                    if (m_axis_tdata[0] !== want.ok)
                        report_mismatch("ok", 64'(m_axis_tdata[0]), 64'(want.ok));
                    if (m_axis_tdata[48:1] !== want.buf_addr)
                        report_mismatch("buf_addr", 64'(m_axis_tdata[48:1]),
                                        64'(want.buf_addr));
                    if (m_axis_tdata[50:49] !== want.size_class)
                        report_mismatch("size_class", 64'(m_axis_tdata[50:49]),
                                        64'(want.size_class));
                    if (m_axis_tdata[OUT_TDATA_W-1:51] !== '0)
                        report_mismatch("padding", 64'(m_axis_tdata[OUT_TDATA_W-1:51]), 64'd0);
                end
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            else if (rx_wait > 0)
                rx_wait--;
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // Long receiver hold-off, armed by the sequencer
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : sequencer
        base_reg  = '0;
        small_reg = 256;
        mid_reg   = 64;
        big_reg   = 64;
        reload_pools();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Defaults: small at 0, mid at 32768, big at 49152, end at 311296
        push_request(FUNC_ALLOC, 16'd0,     48'hFFFF_FFFF_FFFF, ADDR_AS_IS);
        push_request(FUNC_ALLOC, 16'd128,   48'h0,              ADDR_AS_IS);
        push_request(FUNC_ALLOC, 16'd129,   rand48(),           ADDR_AS_IS);
        push_request(FUNC_ALLOC, 16'd256,   rand48(),           ADDR_AS_IS);
        push_request(FUNC_ALLOC, 16'd257,   rand48(),           ADDR_AS_IS);
        push_request(FUNC_ALLOC, 16'd4096,  rand48(),           ADDR_AS_IS);
        push_request(FUNC_ALLOC, 16'd4097,  rand48(),           ADDR_AS_IS);
        push_request(FUNC_ALLOC, 16'hFFFF,  rand48(),           ADDR_AS_IS);
        push_request(FUNC_FREE,  16'hFFFF,  48'd0,              ADDR_AS_IS);
        // same buffer twice: taken bit is already clear
        push_request(FUNC_FREE,  16'd0,     48'd0,              ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'd64,             ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'd32896,          ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'd51200,          ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'd311296,         ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'hFFFF_FFFF_FFFF, ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'h8000_0000_0000, ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'd32768,          ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'd49152,          ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'd34048,          ADDR_AS_IS);
        push_request(FUNC_FREE,  16'd0,     48'd0,              ADDR_HELD);
        push_request(FUNC_ALLOC, 16'd1,     rand48(),           ADDR_AS_IS);
        run_random(300, 55);
        wait_idle();

        // Base moves, buffers stay; no idling and a long receiver stall
        write_reg(REG_BASE, rand48());
        tx_gap_max = 0;
        rx_gap_max = 0;
        run_random(250, 60);
        hold_req++;
        wait_idle();

        // Tiny pools: exhaustion and fallback to larger classes
        write_reg(REG_BASE, 48'd0);
        write_reg(REG_SMALL_COUNT, 48'd2);
        write_reg(REG_MID_COUNT, 48'd1);
        write_reg(REG_BIG_COUNT, 48'd1);
        tx_gap_max = 0;
        rx_gap_max = MAX_GAP;
        repeat (5) push_request(FUNC_ALLOC, 16'd100, rand48(), ADDR_AS_IS);
        run_random(250, 55);
        wait_idle();

        // Only mid buffers, count above the slot number
        write_reg(REG_SMALL_COUNT, 48'd0);
        write_reg(REG_MID_COUNT, 48'd127);
        write_reg(REG_BIG_COUNT, 48'd0);
        tx_gap_max = MAX_GAP;
        rx_gap_max = MAX_GAP;
        run_random(200, 55);
        wait_idle();

        // Saturated counts and regions wrapping past the top of the address space
        write_reg(REG_BASE, 48'hFFFF_FFFF_F000);
        write_reg(REG_SMALL_COUNT, 48'd511);
        write_reg(REG_MID_COUNT, 48'd0);
        write_reg(REG_BIG_COUNT, 48'd127);
        tx_gap_max = MAX_GAP;
        rx_gap_max = 0;
        run_random(250, 55);
        wait_idle();

        // Random counts and base
        write_reg(REG_BASE, rand48());
        write_reg(REG_SMALL_COUNT, 48'($urandom_range(0, 300)));
        write_reg(REG_MID_COUNT, 48'($urandom_range(0, 127)));
        write_reg(REG_BIG_COUNT, 48'($urandom_range(0, 127)));
        tx_gap_max = MAX_GAP;
        rx_gap_max = MAX_GAP;
        run_random(300, 50);
        wait_idle();

        // Back to full pools at the highest base, flood against a stalled receiver
        write_reg(REG_BASE, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SMALL_COUNT, 48'd256);
        write_reg(REG_MID_COUNT, 48'd64);
        write_reg(REG_BIG_COUNT, 48'd64);
        tx_gap_max = 0;
        rx_gap_max = 0;
        run_random(300, 55);
        hold_req++;
        wait_idle();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
